[src/ilt_pkg.sv]
// Shared types, character codes and helpers for the INI line tokenizer.
`default_nettype none
package ilt_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // Token kinds on the result stream.
    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_VALUE   = 2'd2;
    localparam logic [1:0] KIND_REPORT  = 2'd3;

    // Parser phase within a line.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SECTION,
        PH_KEY,
        PH_VSKIP,
        PH_PLAIN,
        PH_QUOTED,
        PH_ESCAPE,
        PH_DISCARD
    } phase_t;

    // What a byte asks to be flushed.
    typedef enum logic [1:0] {
        FL_NONE,
        FL_SECTION,
        FL_PAIR,
        FL_REPORT
    } flush_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAD,
        ST_READ,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;
        logic load_lead;
        logic load_byte;
    } ilt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        flush_t step_flush;
        flush_t flush_mode;
        logic   key_empty;
        logic   idx_last;
        logic   out_free;
    } ilt_status_t;

    // Space, tab or carriage return.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    // Character that follows a backslash inside quotes.
    function automatic logic [7:0] map_escape(input logic [7:0] c);
        case (c)
            CH_LOW_R: map_escape = CH_CR;
            CH_LOW_N: map_escape = CH_LF;
            CH_LOW_T: map_escape = CH_TAB;
            default:  map_escape = c;
        endcase
    endfunction

endpackage
`default_nettype wire

[src/ilt_ctrl.sv]
// Controller state machine: accepts bytes and sequences the token flush.
`default_nettype none
module ilt_ctrl
    import ilt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire ilt_status_t status,
    output ilt_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (status.step_flush)
                        FL_REPORT:  state_next = ST_LEAD;
                        FL_SECTION: state_next = ST_READ;
                        FL_PAIR:    state_next = ST_LEAD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LEAD: begin
                if (status.flush_mode == FL_PAIR && !status.key_empty) begin
                    state_next = ST_READ;
                end else if (status.out_free) begin
                    state_next = (status.flush_mode == FL_REPORT) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.idx_last ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready      = 1'b0;
        cmd.step      = 1'b0;
        cmd.load_lead = 1'b0;
        cmd.load_byte = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
            end
            ST_LEAD: begin
                // A pair with a non-empty key has no leading empty-key result.
                cmd.load_lead = status.out_free &&
                                !(status.flush_mode == FL_PAIR && !status.key_empty);
            end
            ST_EMIT: cmd.load_byte = status.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[src/ilt_dp.sv]
// Datapath: parser state, line store and the output register.
`default_nettype none
module ilt_dp
    import ilt_pkg::*;
#(
    parameter int LINE_BYTES = 60
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_data,
    input  wire ilt_cmd_t    cmd,
    output ilt_status_t      status,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(LINE_BYTES + 1);
    localparam logic [CW:0] LB = (CW + 1)'(LINE_BYTES);

    logic [7:0] line_mem [LINE_BYTES];
    logic [7:0] rd_data_reg;

    phase_t      phase_reg, n_phase, r_phase;
    logic [CW-1:0] sec_reg, key_reg, kt_reg, vl_reg, vt_reg;
    logic [CW-1:0] n_sec, n_key, n_kt, n_vl, n_vt;
    logic        ovf_reg, n_ovf;
    flush_t      fl;
    logic        we;
    logic [AW-1:0] waddr;
    logic [7:0]  wdata;
    logic [CW:0] pos_key, pos_val, pos_sec;

    flush_t      mode_reg;
    logic [CW-1:0] split_reg, total_reg, idx_reg;
    logic [CW:0] pair_total;

    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic [3:0]  m_user_reg;
    logic        m_last_reg;
    logic [1:0]  byte_kind;
    logic        byte_end, byte_last;

    // One parser step for the accepted byte.
    always_comb begin
        n_phase = phase_reg;
        n_sec   = sec_reg;
        n_key   = key_reg;
        n_kt    = kt_reg;
        n_vl    = vl_reg;
        n_vt    = vt_reg;
        n_ovf   = ovf_reg;
        fl      = FL_NONE;
        we      = 1'b0;
        waddr   = '0;
        wdata   = in_byte;
        pos_key = {1'b0, key_reg};
        pos_val = {1'b0, key_reg} + {1'b0, vl_reg};
        pos_sec = {1'b0, sec_reg};
        case (phase_reg)
            PH_IDLE: begin
                if (in_byte == CH_LBRACK) begin
                    we      = 1'b1;
                    n_sec   = CW'(1);
                    n_phase = PH_SECTION;
                end else if (in_byte == CH_SEMI || in_byte == CH_HASH) begin
                    n_phase = PH_DISCARD;
                end else if (in_byte == CH_EQUALS) begin
                    n_key   = '0;
                    n_kt    = '0;
                    n_vl    = '0;
                    n_vt    = '0;
                    n_phase = PH_VSKIP;
                end else if (!(is_blank(in_byte) || in_byte == CH_LF || in_byte == CH_NUL)) begin
                    we      = 1'b1;
                    n_key   = CW'(1);
                    n_kt    = CW'(1);
                    n_vl    = '0;
                    n_vt    = '0;
                    n_phase = PH_KEY;
                end
            end
            PH_SECTION: begin
                if (in_byte == CH_RBRACK || in_byte == CH_LF || in_byte == CH_NUL) begin
                    fl      = FL_SECTION;
                    n_phase = PH_IDLE;
                end else if (pos_sec < LB) begin
                    we    = 1'b1;
                    waddr = pos_sec[AW-1:0];
                    n_sec = sec_reg + CW'(1);
                end else begin
                    n_ovf   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_KEY: begin
                if (in_byte == CH_EQUALS) begin
                    n_key   = kt_reg;
                    n_vl    = '0;
                    n_vt    = '0;
                    n_phase = PH_VSKIP;
                end else if (in_byte == CH_LF) begin
                    n_phase = PH_IDLE;
                end else if (in_byte == CH_NUL) begin
                    n_phase = PH_DISCARD;
                end else if (pos_key < LB) begin
                    we    = 1'b1;
                    waddr = pos_key[AW-1:0];
                    n_key = key_reg + CW'(1);
                    if (!is_blank(in_byte)) begin
                        n_kt = key_reg + CW'(1);
                    end
                end else begin
                    n_ovf   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_VSKIP: begin
                if (is_blank(in_byte)) begin
                    n_phase = PH_VSKIP;
                end else if (in_byte == CH_LF) begin
                    n_phase = PH_IDLE;
                end else if (in_byte == CH_NUL) begin
                    n_phase = PH_DISCARD;
                end else if (in_byte == CH_QUOTE) begin
                    n_vl    = '0;
                    n_phase = PH_QUOTED;
                end else if (pos_key < LB) begin
                    we      = 1'b1;
                    waddr   = pos_key[AW-1:0];
                    n_vl    = CW'(1);
                    n_vt    = CW'(1);
                    n_phase = PH_PLAIN;
                end else begin
                    n_ovf   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_PLAIN: begin
                if (in_byte == CH_LF || in_byte == CH_NUL) begin
                    fl      = FL_PAIR;
                    n_phase = PH_IDLE;
                end else if (pos_val < LB) begin
                    we    = 1'b1;
                    waddr = pos_val[AW-1:0];
                    n_vl  = vl_reg + CW'(1);
                    if (!is_blank(in_byte)) begin
                        n_vt = vl_reg + CW'(1);
                    end
                end else begin
                    n_ovf   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_QUOTED: begin
                if (in_byte == CH_QUOTE || in_byte == CH_CR || in_byte == CH_LF) begin
                    n_vt    = vl_reg;
                    fl      = (vl_reg != '0) ? FL_PAIR : FL_NONE;
                    n_phase = (in_byte == CH_LF) ? PH_IDLE : PH_DISCARD;
                end else if (in_byte == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else if (pos_val < LB) begin
                    we    = 1'b1;
                    waddr = pos_val[AW-1:0];
                    n_vl  = vl_reg + CW'(1);
                end else begin
                    n_ovf   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_ESCAPE: begin
                if (in_byte == CH_CR || in_byte == CH_NUL || in_byte == CH_LF) begin
                    n_vt    = vl_reg;
                    fl      = (vl_reg != '0) ? FL_PAIR : FL_NONE;
                    n_phase = (in_byte == CH_LF) ? PH_IDLE : PH_DISCARD;
                end else if (pos_val < LB) begin
                    we      = 1'b1;
                    waddr   = pos_val[AW-1:0];
                    wdata   = map_escape(in_byte);
                    n_vl    = vl_reg + CW'(1);
                    n_phase = PH_QUOTED;
                end else begin
                    n_ovf   = 1'b1;
                    n_phase = PH_DISCARD;
                end
            end
            PH_DISCARD: begin
                if (in_byte == CH_LF) begin
                    fl      = ovf_reg ? FL_REPORT : FL_NONE;
                    n_ovf   = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        // End of data settles whatever is pending.
        if (end_of_data) begin
            case (n_phase)
                PH_SECTION: fl = FL_SECTION;
                PH_PLAIN:   fl = FL_PAIR;
                PH_QUOTED, PH_ESCAPE: begin
                    n_vt = n_vl;
                    fl   = (n_vl != '0) ? FL_PAIR : FL_NONE;
                end
                PH_DISCARD: begin
                    if (n_ovf) begin
                        fl = FL_REPORT;
                    end
                end
                default: ;
            endcase
        end
    end

    assign r_phase    = end_of_data ? PH_IDLE : n_phase;
    assign pair_total = {1'b0, n_key} + {1'b0, n_vt};

    // Parser state and flush bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sec_reg   <= '0;
            key_reg   <= '0;
            kt_reg    <= '0;
            vl_reg    <= '0;
            vt_reg    <= '0;
            ovf_reg   <= 1'b0;
            mode_reg  <= FL_NONE;
        end else if (cmd.step) begin
            phase_reg <= r_phase;
            sec_reg   <= end_of_data ? '0 : n_sec;
            key_reg   <= end_of_data ? '0 : n_key;
            kt_reg    <= end_of_data ? '0 : n_kt;
            vl_reg    <= end_of_data ? '0 : n_vl;
            vt_reg    <= end_of_data ? '0 : n_vt;
            ovf_reg   <= end_of_data ? 1'b0 : n_ovf;
            mode_reg  <= fl;
        end
    end

    // Flush lengths and the read index.
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            split_reg <= (fl == FL_SECTION) ? n_sec : n_key;
            total_reg <= (fl == FL_SECTION) ? n_sec : pair_total[CW-1:0];
            idx_reg   <= '0;
        end else if (cmd.load_byte) begin
            idx_reg   <= idx_reg + CW'(1);
        end
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.step && we) begin
            line_mem[waddr] <= wdata;
        end
        rd_data_reg <= line_mem[idx_reg[AW-1:0]];
    end

    // Fields of a byte result.
    assign byte_last = (idx_reg + CW'(1)) == total_reg;
    assign byte_end  = byte_last || (mode_reg == FL_PAIR && (idx_reg + CW'(1)) == split_reg);
    assign byte_kind = (mode_reg == FL_SECTION) ? KIND_SECTION :
                       (idx_reg < split_reg) ? KIND_KEY : KIND_VALUE;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_lead || cmd.load_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_lead) begin
            m_data_reg <= 8'h00;
            m_user_reg <= {1'b1, 1'b0,
                           (mode_reg == FL_REPORT) ? KIND_REPORT : KIND_KEY};
            m_last_reg <= (mode_reg == FL_REPORT);
        end else if (cmd.load_byte) begin
            m_data_reg <= rd_data_reg;
            m_user_reg <= {byte_end, 1'b1, byte_kind};
            m_last_reg <= byte_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign status.step_flush = fl;
    assign status.flush_mode = mode_reg;
    assign status.key_empty  = (split_reg == '0);
    assign status.idx_last   = byte_last;
    assign status.out_free   = !m_valid_reg || m_tready;

endmodule
`default_nettype wire

[src/ini_line_tokenizer.sv]
// Top level of the INI line tokenizer.
//
// Takes INI text one byte per input transaction and returns section, key and
// value token bytes and line overflow reports. A byte that settles no token
// does not hold the input. A byte that closes a section is followed, for each
// result, by a read of the line store and then the load of the output
// register. A byte that closes a key and value pair, or that raises an
// overflow report, is followed by the leading result slot, which carries the
// empty-key result or the report where there is one, and then by the same
// read and load for each buffered byte. The input is held for the whole
// flush, and further while the receiver stalls. The output register lets a
// finished result wait for the receiver while the next byte is accepted.
// Lines longer than LINE_BYTES are dropped and reported once.
`default_nettype none
module ini_line_tokenizer
    import ilt_pkg::*;
#(
    parameter int LINE_BYTES = 60
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // end_of_data
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [3:0]      m_tuser,   // token_kind[1:0], has_byte, token_end
    output logic            m_tlast    // run_last
);

    ilt_cmd_t    cmd;
    ilt_status_t status;

    // Controller.
    ilt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    ilt_dp #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_tdata),
        .end_of_data (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

[dv/tb_ilt_checker.sv]
// Checker for the INI line tokenizer: predicts token results and compares them.
`default_nettype none
module tb_ilt_checker
    import ilt_pkg::*;
#(
    parameter int LINE_BYTES = 60
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic [3:0] m_tuser,
    input  wire logic       m_tlast,
    output int              fail_count,
    output int              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected output transaction.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       has;
        logic       tend;
        logic       last;
    } token_res_t;

    token_res_t token_q[$];

    // Predictor state.
    logic [7:0] line_buf[LINE_BYTES];
    phase_t     phase;
    int         sec_len, key_len, key_trim, val_len, val_trim;
    bit         ovf;

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic void push_res(input logic [7:0] b, input logic [1:0] k,
                                     input logic h, input logic e);
        token_res_t r;
        r.data = b; r.kind = k; r.has = h; r.tend = e; r.last = 1'b0;
        token_q.push_back(r);
    endfunction

    function automatic void flush_section();
        for (int i = 0; i < sec_len; i++)
            push_res(line_buf[i], KIND_SECTION, 1'b1, i + 1 == sec_len);
    endfunction

    function automatic void flush_pair();
        if (key_len == 0)
            push_res(8'h00, KIND_KEY, 1'b0, 1'b1);
        for (int i = 0; i < key_len; i++)
            push_res(line_buf[i], KIND_KEY, 1'b1, i + 1 == key_len);
        for (int i = 0; i < val_trim; i++)
            push_res(line_buf[key_len + i], KIND_VALUE, 1'b1, i + 1 == val_trim);
    endfunction

    function automatic void finish_quoted();
        val_trim = val_len;
        if (val_len != 0)
            flush_pair();
    endfunction

    function automatic void store_value(input logic [7:0] c);
        if (key_len + val_len < LINE_BYTES) begin
            line_buf[key_len + val_len] = c;
            val_len++;
        end else begin
            ovf = 1'b1;
            phase = PH_DISCARD;
        end
    endfunction

    function automatic void clear_state();
        phase = PH_IDLE;
        sec_len = 0; key_len = 0; key_trim = 0; val_len = 0; val_trim = 0;
        ovf = 1'b0;
    endfunction

    // Works out the results that one input byte causes.
    function automatic void predict_byte(input logic [7:0] c, input logic eod);
        logic [7:0] m;
        int         first;
        first = token_q.size();
        case (phase)
            PH_IDLE: begin
                if (c == CH_LBRACK) begin
                    line_buf[0] = c; sec_len = 1; phase = PH_SECTION;
                end else if (c == CH_SEMI || c == CH_HASH) begin
                    phase = PH_DISCARD;
                end else if (c == CH_EQUALS) begin
                    key_len = 0; key_trim = 0; val_len = 0; val_trim = 0;
                    phase = PH_VSKIP;
                end else if (!(blank_char(c) || c == CH_LF || c == CH_NUL)) begin
                    line_buf[0] = c; key_len = 1; key_trim = 1;
                    val_len = 0; val_trim = 0; phase = PH_KEY;
                end
            end
            PH_SECTION: begin
                if (c == CH_RBRACK || c == CH_LF || c == CH_NUL) begin
                    flush_section(); phase = PH_IDLE;
                end else if (sec_len < LINE_BYTES) begin
                    line_buf[sec_len] = c; sec_len++;
                end else begin
                    ovf = 1'b1; phase = PH_DISCARD;
                end
            end
            PH_KEY: begin
                if (c == CH_EQUALS) begin
                    key_len = key_trim; val_len = 0; val_trim = 0; phase = PH_VSKIP;
                end else if (c == CH_LF) begin
                    phase = PH_IDLE;
                end else if (c == CH_NUL) begin
                    phase = PH_DISCARD;
                end else if (key_len < LINE_BYTES) begin
                    line_buf[key_len] = c; key_len++;
                    if (!blank_char(c)) key_trim = key_len;
                end else begin
                    ovf = 1'b1; phase = PH_DISCARD;
                end
            end
            PH_VSKIP: begin
                if (blank_char(c)) begin
                end else if (c == CH_LF) begin
                    phase = PH_IDLE;
                end else if (c == CH_NUL) begin
                    phase = PH_DISCARD;
                end else if (c == CH_QUOTE) begin
                    val_len = 0; phase = PH_QUOTED;
                end else if (key_len < LINE_BYTES) begin
                    line_buf[key_len] = c; val_len = 1; val_trim = 1; phase = PH_PLAIN;
                end else begin
                    ovf = 1'b1; phase = PH_DISCARD;
                end
            end
            PH_PLAIN: begin
                if (c == CH_LF || c == CH_NUL) begin
                    flush_pair(); phase = PH_IDLE;
                end else if (key_len + val_len < LINE_BYTES) begin
                    line_buf[key_len + val_len] = c; val_len++;
                    if (!blank_char(c)) val_trim = val_len;
                end else begin
                    ovf = 1'b1; phase = PH_DISCARD;
                end
            end
            PH_QUOTED: begin
                if (c == CH_QUOTE || c == CH_CR) begin
                    finish_quoted(); phase = PH_DISCARD;
                end else if (c == CH_LF) begin
                    finish_quoted(); phase = PH_IDLE;
                end else if (c == CH_BSLASH) begin
                    phase = PH_ESCAPE;
                end else begin
                    store_value(c);
                end
            end
            PH_ESCAPE: begin
                if (c == CH_CR || c == CH_NUL) begin
                    finish_quoted(); phase = PH_DISCARD;
                end else if (c == CH_LF) begin
                    finish_quoted(); phase = PH_IDLE;
                end else begin
                    m = c;
                    if (c == CH_LOW_R) m = CH_CR;
                    else if (c == CH_LOW_N) m = CH_LF;
                    else if (c == CH_LOW_T) m = CH_TAB;
                    phase = PH_QUOTED;
                    store_value(m);
                end
            end
            PH_DISCARD: begin
                if (c == CH_LF) begin
                    if (ovf) push_res(8'h00, KIND_REPORT, 1'b0, 1'b1);
                    ovf = 1'b0; phase = PH_IDLE;
                end
            end
            default: phase = PH_IDLE;
        endcase

        // End of data closes whatever is pending.
        if (eod) begin
            if (phase == PH_SECTION) flush_section();
            else if (phase == PH_PLAIN) flush_pair();
            else if (phase == PH_QUOTED || phase == PH_ESCAPE) finish_quoted();
            else if (phase == PH_DISCARD && ovf)
                push_res(8'h00, KIND_REPORT, 1'b0, 1'b1);
            clear_state();
        end

        if (token_q.size() > first)
            token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // Predict on input transactions, compare on output transactions.
    always @(posedge aclk) begin
        token_res_t exp_r;
        token_res_t got;
        if (!aresetn) begin
            clear_state();
            token_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser[1:0], m_tuser[2], m_tuser[3], m_tlast};
                if (token_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $realtime, got);
                    fail_count++;
                end else begin
                    exp_r = token_q.pop_front();
                    if (got != exp_r) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: expected data %h kind %0d has %b end %b last %b,",
                                     $realtime, exp_r.data, exp_r.kind, exp_r.has,
                                     exp_r.tend, exp_r.last,
                                     " got data %h kind %0d has %b end %b last %b",
                                     got.data, got.kind, got.has, got.tend, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
        end
        pending_count = token_q.size();
    end

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench top for the INI line tokenizer: drives INI text and gives the verdict.
`default_nettype none
module tb_top;
    import ilt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTES = 60;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;
    int         fail_count;
    int         pending_count;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic [7:0] text_q[$];

    always #6 aclk = ~aclk;

    ini_line_tokenizer #(.LINE_BYTES(LINE_BYTES)) dut (.*);

    tb_ilt_checker #(.LINE_BYTES(LINE_BYTES)) chk (.*);

    // The receiver stalls at random by the current percentage.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Sends one byte as a transaction, with random idle cycles ahead of it.
    // The valid stays high after the transaction until the next idle cycle.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends a whole string as text bytes.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_char();
        case ($urandom_range(11))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_BSLASH;
            3: return CH_QUOTE;
            4: return 8'($urandom_range(255));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    // Builds one random INI line, mostly well formed.
    task automatic build_line();
        int n;
        int sel;
        n = ($urandom_range(15) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 6);
        sel = $urandom_range(9);
        if (sel < 2) begin
            text_q.push_back(CH_LBRACK);
            repeat (n) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            if ($urandom_range(1)) text_q.push_back(CH_RBRACK);
        end else if (sel < 8) begin
            repeat ($urandom_range(2)) text_q.push_back(CH_SPACE);
            repeat (n) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            repeat ($urandom_range(2)) text_q.push_back(CH_TAB);
            if ($urandom_range(7) != 0) text_q.push_back(CH_EQUALS);
            repeat ($urandom_range(2)) text_q.push_back(CH_SPACE);
            if ($urandom_range(2) == 0) begin
                text_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5)) text_q.push_back(rand_char());
                if ($urandom_range(1)) text_q.push_back(CH_QUOTE);
            end else begin
                repeat ($urandom_range(0, 5)) text_q.push_back(rand_char());
            end
        end else if (sel == 8) begin
            text_q.push_back($urandom_range(1) ? CH_SEMI : CH_HASH);
            repeat (n) text_q.push_back(rand_char());
        end else begin
            repeat (n) text_q.push_back(8'($urandom_range(255)));
        end
        text_q.push_back($urandom_range(9) == 0 ? CH_CR : CH_LF);
        if ($urandom_range(1)) text_q.push_back(CH_LF);
    endtask

    task automatic run_random(input int nbytes);
        int sent;
        sent = 0;
        while (sent < nbytes) begin
            if (text_q.size() == 0) build_line();
            send_byte(text_q.pop_front(), $urandom_range(40) == 0);
            sent++;
        end
    endtask

    // Stimulus.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: section, comments, trimmed pair, empty key, quoted escapes.
        send_text("[sec]k = v \n; c\n#x\n=v\nq=\"a\\tb\\n\\r\\\\\" z\n");

        // Directed: zero bytes in a key, a section, inside quotes and after a backslash in quotes.
        send_text("a");
        send_byte(CH_NUL, 1'b0);
        send_text("\n[s");
        send_byte(CH_NUL, 1'b0);
        send_text("p=\"");
        send_byte(CH_NUL, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(8'hFF, 1'b1);
        s_tvalid <= 1'b0;

        // Pause until every expected result has come.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);

        // Overflowing line, then an end of data inside a quoted value.
        repeat (LINE_BYTES + 2) send_byte(8'h6B, 1'b0);
        send_text("\nk=\"x");
        send_byte(8'h79, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 30 : 76) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 30 : 76) : 0;
            run_random(60);
        end
        send_byte(CH_LF, 1'b1);
        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
src/ilt_pkg.sv
src/ilt_ctrl.sv
src/ilt_dp.sv
src/ini_line_tokenizer.sv
dv/tb_ilt_checker.sv
dv/tb_top.sv
